>>> rtl/page_allocator_refcount_top_assert.svh
// ----------------------------------------------------------------------------
// Page allocator assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PAGE_ALLOCATOR_REFCOUNT_TOP_ASSERT_SVH
`define PAGE_ALLOCATOR_REFCOUNT_TOP_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define PAR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PAR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/par_pkg.sv
// ----------------------------------------------------------------------------
// Page allocator package
// Field widths, operation and status codes, controller types.
// ----------------------------------------------------------------------------
package par_pkg;

  localparam int ADDR_W     = 40;
  localparam int BASE_W     = 28;
  localparam int PCNT_W     = 16;
  localparam int MODE_W     = 3;
  localparam int STATUS_W   = 3;
  localparam int OUT_CNT_W  = 16;
  localparam int PAGE_SHIFT = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 28;

  localparam logic [PCNT_W-1:0] PCOUNT_RESET = 16'd32768;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_PAGE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 2'd1;

  localparam logic [MODE_W-1:0] MODE_INIT  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FREE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REF   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DEREF = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OOM     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADADDR = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SAT     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVF     = 3'd4;

  typedef enum logic [2:0] {
    S_CLEAR_RST,
    S_IDLE,
    S_LOOKUP,
    S_CLEAR_INIT,
    S_EXEC
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic lookup;
    logic clr_en;
    logic exec;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode_init;
    logic sweep_last;
    logic out_free;
  } dp_stat_t;

endpackage

>>> rtl/par_in_if.sv
// ----------------------------------------------------------------------------
// Page allocator request channel
// Valid/ready channel carrying one allocator operation.
// ----------------------------------------------------------------------------
interface par_in_if;
  import par_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ADDR_W-1:0] phys_address;

  modport source (output valid, output mode, output phys_address, input ready);
  modport sink   (input valid, input mode, input phys_address, output ready);
endinterface

>>> rtl/par_out_if.sv
// ----------------------------------------------------------------------------
// Page allocator response channel
// Valid/ready channel carrying the result of one operation.
// ----------------------------------------------------------------------------
interface par_out_if;
  import par_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [ADDR_W-1:0]    page_address;
  logic                 page_freed;
  logic [OUT_CNT_W-1:0] count_after;

  modport source (output valid, output status, output page_address, output page_freed,
                  output count_after, input ready);
  modport sink   (input valid, input status, input page_address, input page_freed,
                  input count_after, output ready);
endinterface

>>> rtl/par_cfg_if.sv
// ----------------------------------------------------------------------------
// Page allocator configuration channel
// Valid/ready register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface par_cfg_if;
  import par_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/page_allocator_refcount_top.sv
// ----------------------------------------------------------------------------
// Page allocator with reference counts, top level
// Physical page frame allocator with a free stack and per-page counts.
// ----------------------------------------------------------------------------
// The request channel (in_chan) carries one operation per transaction: init,
// alloc, free, ref or deref, with the page byte address. The response channel
// (out_chan) returns exactly one transaction per request, in order. The
// configuration channel (cfg_chan) writes base_page (index 0) and page_count
// (index 1); it is always ready. A new page_count bounds the address check at
// once and sets the untouched pages at the next init. Configure only while
// no request is outstanding. A request is loaded when accepted, then looked
// up in the count and stack memories, then committed into them and into the
// result register; the commit waits while the result register is still
// full. One request is in flight at a time, so a new one is not taken until
// the previous one has committed. Init also sweeps the count memory, one
// entry a cycle, before it commits.
// After reset the same sweep clears every count: in_chan.ready stays low until
// the sweep is done. A stalled response waits in the result register; the next
// request is still taken and waits at its commit step until the slot frees.
// ----------------------------------------------------------------------------
`include "page_allocator_refcount_top_assert.svh"

module page_allocator_refcount_top #(
  parameter int NUM_PAGES   = 32768,
  parameter int COUNT_WIDTH = 16
) (
  input logic       clk,
  input logic       rst_n,
  par_in_if.sink    in_chan,
  par_out_if.source out_chan,
  par_cfg_if.sink   cfg_chan
);
  import par_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Configuration writes are always accepted and never stalled.
  assign cfg_chan.ready = 1'b1;

  // The controller owns the request handshake and sequences the datapath.
  par_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the registers, both memories and the result slot.
  par_dp #(
    .NUM_PAGES   (NUM_PAGES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_mode          (in_chan.mode),
    .in_phys_address  (in_chan.phys_address),
    .cfg_we           (cfg_chan.valid),
    .cfg_index        (cfg_chan.index),
    .cfg_data         (cfg_chan.data),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_status       (out_chan.status),
    .out_page_address (out_chan.page_address),
    .out_page_freed   (out_chan.page_freed),
    .out_count_after  (out_chan.count_after)
  );

  // A request is followed by its lookup, so the block is busy right after.
  `PAR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_chan.valid && in_chan.ready, !in_chan.ready, "request accepted while previous one in flight")
  // A commit always leaves a response waiting in the result register.
  `PAR_ASSERT_NEXT(a_result_after_commit, clk, rst_n, cmd.exec, out_chan.valid, "commit did not produce a response")
  // The count sweep owns the count memory: no request and no commit beside it.
  `PAR_ASSERT_SAME(a_sweep_exclusive, clk, rst_n, cmd.clr_en, !in_chan.ready && !cmd.exec && !cmd.lookup, "count sweep overlaps other work")

endmodule

>>> rtl/par_ram.sv
// ----------------------------------------------------------------------------
// Page allocator generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module par_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/par_ctrl.sv
// ----------------------------------------------------------------------------
// Page allocator controller
// Sequences lookup and commit for each operation, and the count-memory sweep after reset and for init.
// ----------------------------------------------------------------------------
module par_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  par_pkg::dp_stat_t   stat,
  output par_pkg::ctrl_cmd_t  cmd
);
  import par_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR_RST;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR_RST: begin
        cmd.clr_en = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = stat.mode_init ? S_CLEAR_INIT : S_EXEC;
      end
      S_CLEAR_INIT: begin
        cmd.clr_en = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // Commit only when the result register can take the result.
        if (stat.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/par_dp.sv
// ----------------------------------------------------------------------------
// Page allocator datapath
// Configuration, stack and count memories, address check and result register.
// ----------------------------------------------------------------------------
module par_dp #(
  parameter int NUM_PAGES   = 32768,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  par_pkg::ctrl_cmd_t             cmd,
  output par_pkg::dp_stat_t              stat,
  input  logic [par_pkg::MODE_W-1:0]     in_mode,
  input  logic [par_pkg::ADDR_W-1:0]     in_phys_address,
  input  logic                           cfg_we,
  input  logic [par_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [par_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [par_pkg::STATUS_W-1:0]   out_status,
  output logic [par_pkg::ADDR_W-1:0]     out_page_address,
  output logic                           out_page_freed,
  output logic [par_pkg::OUT_CNT_W-1:0]  out_count_after
);
  import par_pkg::*;

  localparam int IDX_W = $clog2(NUM_PAGES);
  localparam int CNT_W = $clog2(NUM_PAGES + 1);
  localparam logic [CNT_W-1:0] UNT_RESET =
    CNT_W'((NUM_PAGES < int'(PCOUNT_RESET)) ? NUM_PAGES : int'(PCOUNT_RESET));
  localparam logic [CNT_W-1:0]       PAGES_MAX  = CNT_W'(NUM_PAGES);
  localparam logic [IDX_W-1:0]       SWEEP_LAST = IDX_W'(NUM_PAGES - 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = '1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_ONE  = COUNT_WIDTH'(1);

  // Operation and configuration registers.
  logic [MODE_W-1:0] mode_r;
  logic [ADDR_W-1:0] pa_r;
  logic [IDX_W-1:0]  idx_r;
  logic              bad_r;
  logic [BASE_W-1:0] base_r;
  logic [PCNT_W-1:0] pcount_r;
  logic [IDX_W-1:0]  sweep_r;
  logic [CNT_W-1:0]  depth_r;
  logic [CNT_W-1:0]  depth_nxt;
  logic [CNT_W-1:0]  unt_r;
  logic [CNT_W-1:0]  unt_nxt;

  // Result register.
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  status_r;
  logic [ADDR_W-1:0]    addr_r;
  logic                 freed_r;
  logic [OUT_CNT_W-1:0] cnt_out_r;

  // Memory ports.
  logic [COUNT_WIDTH-1:0] cnt_rd;
  logic [IDX_W-1:0]       stk_rd;
  logic                   cnt_ram_we;
  logic [IDX_W-1:0]       cnt_ram_wa;
  logic [COUNT_WIDTH-1:0] cnt_ram_wd;

  // Lookup logic.
  logic [CNT_W-1:0]  limit_c;
  logic [BASE_W-1:0] frame_c;
  logic [BASE_W-1:0] diff_c;
  logic              addr_ok_c;
  logic [CNT_W-1:0]  depth_m1_c;
  logic [CNT_W-1:0]  unt_m1_c;

  // Commit logic.
  logic [STATUS_W-1:0]    st_c;
  logic [ADDR_W-1:0]      addr_c;
  logic                   freed_c;
  logic [COUNT_WIDTH-1:0] cnt_c;
  logic                   cnt_we_c;
  logic [IDX_W-1:0]       cnt_wa_c;
  logic [COUNT_WIDTH-1:0] cnt_wd_c;
  logic                   rel_c;
  logic                   push_c;
  logic                   pop_c;
  logic                   take_c;
  logic                   init_c;
  logic                   full_c;
  logic [IDX_W-1:0]       alloc_idx_c;

  assign limit_c    = (32'(pcount_r) < 32'(NUM_PAGES)) ? CNT_W'(pcount_r) : PAGES_MAX;
  assign frame_c    = pa_r[ADDR_W-1:PAGE_SHIFT];
  assign diff_c     = frame_c - base_r;
  assign addr_ok_c  = (pa_r[PAGE_SHIFT-1:0] == '0) && (frame_c >= base_r) &&
                      (diff_c < BASE_W'(limit_c));
  assign depth_m1_c = depth_r - 1'b1;
  assign unt_m1_c   = unt_r - 1'b1;
  assign full_c     = (depth_r >= PAGES_MAX);
  assign alloc_idx_c = (depth_r != '0) ? stk_rd : unt_m1_c[IDX_W-1:0];

  always_comb begin
    st_c     = ST_OK;
    addr_c   = '0;
    freed_c  = 1'b0;
    cnt_c    = '0;
    cnt_we_c = 1'b0;
    cnt_wa_c = idx_r;
    cnt_wd_c = '0;
    rel_c    = 1'b0;
    push_c   = 1'b0;
    pop_c    = 1'b0;
    take_c   = 1'b0;
    init_c   = 1'b0;
    unique case (mode_r) inside
      MODE_INIT: begin
        init_c = 1'b1;
      end
      MODE_ALLOC: begin
        if (depth_r != '0) begin
          pop_c = 1'b1;
        end else if (unt_r != '0) begin
          take_c = 1'b1;
        end else begin
          st_c = ST_OOM;
        end
        if (pop_c || take_c) begin
          cnt_we_c = 1'b1;
          cnt_wa_c = alloc_idx_c;
          cnt_wd_c = COUNT_ONE;
          cnt_c    = COUNT_ONE;
          addr_c   = {base_r + BASE_W'(alloc_idx_c), {PAGE_SHIFT{1'b0}}};
        end
      end
      MODE_FREE, MODE_REF, MODE_DEREF: begin
        if (bad_r) begin
          st_c = ST_BADADDR;
        end else if (mode_r == MODE_FREE) begin
          cnt_we_c = 1'b1;
          rel_c    = 1'b1;
        end else if (mode_r == MODE_REF) begin
          if (cnt_rd == COUNT_MAX) begin
            st_c  = ST_SAT;
            cnt_c = cnt_rd;
          end else begin
            cnt_we_c = 1'b1;
            cnt_wd_c = cnt_rd + 1'b1;
            cnt_c    = cnt_rd + 1'b1;
          end
        end else begin
          if (cnt_rd == '0) begin
            st_c = ST_SAT;
          end else begin
            cnt_we_c = 1'b1;
            cnt_wd_c = cnt_rd - 1'b1;
            cnt_c    = cnt_rd - 1'b1;
            rel_c    = (cnt_rd == COUNT_ONE);
          end
        end
      end
      default: begin
        // Undefined operations leave the state alone and answer zeros.
      end
    endcase
    // A released page goes on the stack unless the stack is already full.
    if (rel_c) begin
      if (full_c) begin
        st_c = ST_OVF;
      end else begin
        push_c  = 1'b1;
        freed_c = 1'b1;
      end
    end
  end

  always_comb begin
    depth_nxt = depth_r;
    unt_nxt   = unt_r;
    if (cmd.exec) begin
      if (init_c) begin
        depth_nxt = '0;
        unt_nxt   = limit_c;
      end else if (pop_c) begin
        depth_nxt = depth_m1_c;
      end else if (push_c) begin
        depth_nxt = depth_r + 1'b1;
      end
      if (take_c) begin
        unt_nxt = unt_m1_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      pcount_r    <= PCOUNT_RESET;
      sweep_r     <= '0;
      depth_r     <= '0;
      unt_r       <= UNT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == CFG_BASE_PAGE)) begin
        base_r <= cfg_data[BASE_W-1:0];
      end
      if (cfg_we && (cfg_index == CFG_PAGE_COUNT)) begin
        pcount_r <= cfg_data[PCNT_W-1:0];
      end
      if (cmd.clr_en) begin
        sweep_r <= (sweep_r == SWEEP_LAST) ? '0 : sweep_r + 1'b1;
      end
      depth_r <= depth_nxt;
      unt_r   <= unt_nxt;
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r <= in_mode;
      pa_r   <= in_phys_address;
    end
    if (cmd.lookup) begin
      idx_r <= diff_c[IDX_W-1:0];
      bad_r <= !addr_ok_c;
    end
    if (cmd.exec) begin
      status_r  <= st_c;
      addr_r    <= addr_c;
      freed_r   <= freed_c;
      cnt_out_r <= OUT_CNT_W'(cnt_c);
    end
  end

  assign cnt_ram_we = cmd.clr_en || (cmd.exec && cnt_we_c);
  assign cnt_ram_wa = cmd.clr_en ? sweep_r : cnt_wa_c;
  assign cnt_ram_wd = cmd.clr_en ? '0 : cnt_wd_c;

  par_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_PAGES)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_ram_we),
    .waddr (cnt_ram_wa),
    .wdata (cnt_ram_wd),
    .re    (cmd.lookup),
    .raddr (diff_c[IDX_W-1:0]),
    .rdata (cnt_rd)
  );

  par_ram #(
    .WIDTH (IDX_W),
    .DEPTH (NUM_PAGES)
  ) u_stack_ram (
    .clk   (clk),
    .we    (cmd.exec && push_c),
    .waddr (depth_r[IDX_W-1:0]),
    .wdata (idx_r),
    .re    (cmd.lookup),
    .raddr (depth_m1_c[IDX_W-1:0]),
    .rdata (stk_rd)
  );

  assign stat.mode_init  = (mode_r == MODE_INIT);
  assign stat.sweep_last = (sweep_r == SWEEP_LAST);
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_page_address = addr_r;
  assign out_page_freed   = freed_r;
  assign out_count_after  = cnt_out_r;

endmodule
